[hw/rtl/msht_pkg.sv]
// ----------------------------------------------------------------------------
// msht_pkg
// Shared types and codes for the memory-share handle table.
// ----------------------------------------------------------------------------
`default_nettype none

package msht_pkg;

    // Default table depth
    localparam int ENTRIES_DEF = 16;

    // Field widths
    localparam int OP_W     = 3;
    localparam int KIND_W   = 2;
    localparam int REQ_H_W  = 64;
    localparam int HANDLE_W = 63;
    localparam int ID_W     = 16;
    localparam int STATE_W  = 2;
    localparam int STAT_W   = 2;
    localparam int COUNT_W  = 64;

    // Operation codes
    localparam logic [OP_W-1:0] OP_ALLOC      = 3'd0;
    localparam logic [OP_W-1:0] OP_LOOKUP     = 3'd1;
    localparam logic [OP_W-1:0] OP_RETRIEVE   = 3'd2;
    localparam logic [OP_W-1:0] OP_RELINQUISH = 3'd3;
    localparam logic [OP_W-1:0] OP_RECLAIM    = 3'd4;

    // Transfer kind that leaves the slot free
    localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

    // Slot states
    localparam logic [STATE_W-1:0] ES_FREE = 2'd0;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_INVALID = 2'd1;
    localparam logic [STAT_W-1:0] STAT_DENIED  = 2'd2;
    localparam logic [STAT_W-1:0] STAT_NOMEM   = 2'd3;

    // Counter value after reset
    localparam logic [COUNT_W-1:0] COUNT_INIT = 64'd1;

    // Request word
    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [KIND_W-1:0]  transfer_kind;
        logic [REQ_H_W-1:0] handle;
        logic [ID_W-1:0]    owner_id;
        logic [ID_W-1:0]    borrower_id;
    } in_word_t;

    // Result word
    typedef struct packed {
        logic [STAT_W-1:0]   status;
        logic [HANDLE_W-1:0] handle_out;
        logic [ID_W-1:0]     found_owner;
        logic [ID_W-1:0]     found_borrower;
        logic [STATE_W-1:0]  found_state;
        logic                found_retrieved;
    } out_word_t;

    // One table slot as held in the RAM
    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [ID_W-1:0]     owner;
        logic [ID_W-1:0]     borrower;
        logic [STATE_W-1:0]  state;
        logic                retrieved;
    } entry_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic scan;
        logic finish;
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic hit;
        logic miss;
    } dp_stat_t;

endpackage

`default_nettype wire

[hw/rtl/msht_ram.sv]
// ----------------------------------------------------------------------------
// msht_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module msht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[hw/rtl/msht_dp.sv]
// ----------------------------------------------------------------------------
// msht_dp
// Datapath: request register, slot scan, table RAM, handle counter, result.
// ----------------------------------------------------------------------------
`default_nettype none

module msht_dp #(
    parameter int ENTRIES = msht_pkg::ENTRIES_DEF,
    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
    localparam int CNT_W = $clog2(ENTRIES + 1)
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire msht_pkg::in_word_t  s_data,
    output msht_pkg::out_word_t      m_data,
    input  wire msht_pkg::dp_cmd_t   cmd,
    output msht_pkg::dp_stat_t       stat
);

    localparam int ENTRY_W = $bits(msht_pkg::entry_t);

    msht_pkg::in_word_t                  req_reg;
    logic [CNT_W-1:0]                    idx_reg;
    logic                                rd_vld_reg;
    logic [IDX_W-1:0]                    rd_idx_reg;
    logic                                found_reg;
    logic [IDX_W-1:0]                    hit_idx_reg;
    msht_pkg::entry_t                    hit_entry_reg;
    logic [ENTRIES-1:0]                  valid_reg;
    logic [msht_pkg::COUNT_W-1:0]        counter_reg;
    msht_pkg::out_word_t                 result_reg;

    logic [ENTRY_W-1:0]                  ram_rdata;
    msht_pkg::entry_t                    rd_entry;
    logic                                hit_cand;
    logic                                hit_now;
    logic                                last;
    msht_pkg::out_word_t                 res;
    msht_pkg::entry_t                    wr_entry;
    logic                                wr_en;
    logic                                cnt_inc;

    // Table storage
    msht_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .aclk  (aclk),
        .we    (cmd.finish & wr_en),
        .waddr (hit_idx_reg),
        .wdata (wr_entry),
        .raddr (idx_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    // Slot as read: never-written slots read as free and not retrieved
    always_comb begin
        rd_entry = msht_pkg::entry_t'(ram_rdata);
        if (!valid_reg[rd_idx_reg]) begin
            rd_entry.state     = msht_pkg::ES_FREE;
            rd_entry.retrieved = 1'b0;
        end
    end

    // Match test for the slot just read
    always_comb begin
        case (req_reg.op) inside
            msht_pkg::OP_ALLOC: begin
                hit_cand = (rd_entry.state == msht_pkg::ES_FREE);
            end
            msht_pkg::OP_LOOKUP, msht_pkg::OP_RETRIEVE,
            msht_pkg::OP_RELINQUISH, msht_pkg::OP_RECLAIM: begin
                hit_cand = (rd_entry.state != msht_pkg::ES_FREE) &&
                           !req_reg.handle[msht_pkg::REQ_H_W-1] &&
                           (rd_entry.handle == req_reg.handle[msht_pkg::HANDLE_W-1:0]);
            end
            default: begin
                hit_cand = 1'b0;
            end
        endcase
    end

    assign hit_now   = rd_vld_reg & hit_cand;
    assign last      = (idx_reg == CNT_W'(ENTRIES));
    assign stat.hit  = hit_now;
    assign stat.miss = !hit_now && last;

    // Request capture and slot scan, one slot a cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg    <= '0;
            rd_vld_reg <= 1'b0;
            found_reg  <= 1'b0;
        end else if (cmd.load) begin
            idx_reg    <= '0;
            rd_vld_reg <= 1'b0;
            found_reg  <= 1'b0;
        end else if (cmd.scan) begin
            if (hit_now) begin
                found_reg  <= 1'b1;
                rd_vld_reg <= 1'b0;
            end else if (!last) begin
                rd_vld_reg <= 1'b1;
                idx_reg    <= idx_reg + CNT_W'(1);
            end else begin
                rd_vld_reg <= 1'b0;
            end
        end
    end

    // Payload side of the scan
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg <= s_data;
        end
        if (cmd.scan && !hit_now && !last) begin
            rd_idx_reg <= idx_reg[IDX_W-1:0];
        end
        if (cmd.scan && hit_now) begin
            hit_idx_reg   <= rd_idx_reg;
            hit_entry_reg <= rd_entry;
        end
    end

    // Operation outcome and slot update
    always_comb begin
        res                 = '0;
        res.status          = msht_pkg::STAT_INVALID;
        wr_entry            = hit_entry_reg;
        wr_en               = 1'b0;
        cnt_inc             = 1'b0;
        case (req_reg.op)
            msht_pkg::OP_ALLOC: begin
                if (found_reg) begin
                    wr_entry.handle    = counter_reg[msht_pkg::HANDLE_W-1:0];
                    wr_entry.owner     = req_reg.owner_id;
                    wr_entry.borrower  = req_reg.borrower_id;
                    wr_entry.state     = (req_reg.transfer_kind == msht_pkg::KIND_NONE) ?
                                         msht_pkg::ES_FREE :
                                         msht_pkg::STATE_W'(req_reg.transfer_kind + 2'd1);
                    wr_entry.retrieved = 1'b0;
                    wr_en              = 1'b1;
                    cnt_inc            = 1'b1;
                    res.status         = msht_pkg::STAT_OK;
                    res.handle_out     = counter_reg[msht_pkg::HANDLE_W-1:0];
                end else begin
                    res.status = msht_pkg::STAT_NOMEM;
                end
            end
            msht_pkg::OP_LOOKUP: begin
                if (found_reg) begin
                    res.status          = msht_pkg::STAT_OK;
                    res.found_owner     = hit_entry_reg.owner;
                    res.found_borrower  = hit_entry_reg.borrower;
                    res.found_state     = hit_entry_reg.state;
                    res.found_retrieved = hit_entry_reg.retrieved;
                end
            end
            msht_pkg::OP_RETRIEVE: begin
                if (found_reg) begin
                    if (hit_entry_reg.borrower != req_reg.borrower_id ||
                        hit_entry_reg.retrieved) begin
                        res.status = msht_pkg::STAT_DENIED;
                    end else begin
                        wr_entry.retrieved = 1'b1;
                        wr_en              = 1'b1;
                        res.status         = msht_pkg::STAT_OK;
                    end
                end
            end
            msht_pkg::OP_RELINQUISH: begin
                if (found_reg) begin
                    if (hit_entry_reg.borrower != req_reg.borrower_id ||
                        !hit_entry_reg.retrieved) begin
                        res.status = msht_pkg::STAT_DENIED;
                    end else begin
                        wr_entry.retrieved = 1'b0;
                        wr_en              = 1'b1;
                        res.status         = msht_pkg::STAT_OK;
                    end
                end
            end
            msht_pkg::OP_RECLAIM: begin
                if (found_reg) begin
                    if (hit_entry_reg.owner != req_reg.owner_id ||
                        hit_entry_reg.retrieved) begin
                        res.status = msht_pkg::STAT_DENIED;
                    end else begin
                        wr_entry.state = msht_pkg::ES_FREE;
                        wr_en          = 1'b1;
                        res.status     = msht_pkg::STAT_OK;
                    end
                end
            end
            default: begin
                res.status = msht_pkg::STAT_INVALID;
            end
        endcase
    end

    // Slot valid bits and handle counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= '0;
            counter_reg <= msht_pkg::COUNT_INIT;
        end else if (cmd.finish) begin
            if (wr_en) begin
                valid_reg[hit_idx_reg] <= 1'b1;
            end
            if (cnt_inc) begin
                counter_reg <= counter_reg + msht_pkg::COUNT_W'(1);
            end
        end
    end

    // Result word
    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            result_reg <= res;
        end
    end

    assign m_data = result_reg;

    // Counter only moves when an operation completes
    a_count_on_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && counter_reg != $past(counter_reg)) |-> $past(cmd.finish))
        else $error("handle counter moved outside completion");

    // Scan index stays within the table
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg <= CNT_W'(ENTRIES))
        else $error("scan index beyond table");

    // A pending read always refers to a real slot
    a_rd_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_vld_reg |-> (CNT_W'(rd_idx_reg) < CNT_W'(ENTRIES)))
        else $error("read of slot beyond table");

endmodule

`default_nettype wire

[hw/rtl/msht_ctrl.sv]
// ----------------------------------------------------------------------------
// msht_ctrl
// Controller: sequences request capture, slot scan and completion, and owns
// the result word's valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module msht_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output msht_pkg::dp_cmd_t       cmd,
    input  wire msht_pkg::dp_stat_t stat
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_REPLY = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;
    logic   out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid & s_ready;
    assign out_free = !out_valid_reg || m_ready;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (stat.hit || stat.miss) begin
                    state_next = ST_REPLY;
                end
            end
            ST_REPLY: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath commands
    always_comb begin
        cmd.load   = accept;
        cmd.scan   = (state_reg == ST_SCAN);
        cmd.finish = (state_reg == ST_REPLY) && out_free;
    end

    // Result word valid flag
    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.finish) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_valid = out_valid_reg;

    // Completion never overwrites a word that is still waiting
    a_finish_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> (!out_valid_reg || m_ready))
        else $error("result overwritten while stalled");

    // A new word appears only from the reply step
    a_valid_from_reply: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && $rose(out_valid_reg)) |-> $past(state_reg == ST_REPLY))
        else $error("result valid without completion");

    // An accepted request always starts a scan
    a_accept_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == ST_SCAN))
        else $error("accepted request did not start a scan");

endmodule

`default_nettype wire

[hw/rtl/memory_share_handle_table.sv]
// ----------------------------------------------------------------------------
// memory_share_handle_table
// Table of memory-transfer handles: alloc, lookup, retrieve, relinquish and
// reclaim, one operation per request word.
//
// Usage:
//   s_valid/s_ready/s_data carry one request word per operation; m_valid/
//   m_ready/m_data return exactly one result word for each request, in order.
//   Requests are taken one at a time. After a request is taken the table is
//   scanned one slot per cycle through the single read port of the table RAM,
//   stopping at the first matching slot, then a reply step completes the update.
//   The result word sits in an output register, so the next request is taken
//   while an earlier result still waits; if the receiver stalls, the following
//   request finishes its scan and then holds until the output is free.
//   Reset (synchronous, aresetn low) marks every slot free and not retrieved
//   and sets the handle counter to one; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module memory_share_handle_table #(
    parameter int ENTRIES = msht_pkg::ENTRIES_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire msht_pkg::in_word_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output msht_pkg::out_word_t      m_data
);

    msht_pkg::dp_cmd_t  cmd;
    msht_pkg::dp_stat_t stat;

    // Sequencer
    msht_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    // Table, counter and result
    msht_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_data  (m_data),
        .cmd     (cmd),
        .stat    (stat)
    );

endmodule

`default_nettype wire
